[src/abp_pkg.sv]
// Shared types, constants and the fixed-point interpolation function of the Bezier plotter.
package abp_pkg;

   localparam int COORD_W = 10;
   localparam int FRAC_W = 16;
   localparam int POS_W = COORD_W + FRAC_W;
   localparam int T_W = 17;
   localparam int PIX_W = 12;
   localparam int INTEN_W = 8;
   localparam int NUM_PTS = 4;
   localparam int NUM_WRITES = 9;
   localparam int K_W = 4;
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int REG_IDX_W = 3;
   localparam int DEFAULT_CANVAS_SIZE = 1024;
   localparam int CANVAS_CMP_W = 13;

   // Widths of the distance and weight arithmetic.
   localparam int D_W = 20;
   localparam int SQ_W = 35;
   localparam int D2_W = 36;
   localparam int W_W = 17;
   localparam int WW_W = 34;
   localparam int SCALE_W = 42;
   localparam int INT_TOP_W = 10;

   localparam logic [T_W-1:0] T_ONE = 17'h1_0000;
   localparam logic [D2_W-1:0] D2_LIM = 36'h8_0000_0000;
   localparam logic [INTEN_W-1:0] FULL_INTENSITY = 8'd255;
   localparam logic [INTEN_W-1:0] ZERO_INTENSITY = 8'd0;

   localparam logic [K_W-1:0] FIRST_K = 4'd0;
   localparam logic [K_W-1:0] BASE_K = 4'd1;
   localparam logic [K_W-1:0] LAST_K = 4'd8;

   // Neighborhood write order, column and row offsets from the base pixel.
   localparam logic signed [1:0] OFF_X [NUM_WRITES] = '{
      2'sd0, 2'sd0, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd1, 2'sd1, 2'sd1};
   localparam logic signed [1:0] OFF_Y [NUM_WRITES] = '{
      -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1};

   typedef enum logic [REG_IDX_W-1:0] {
      REG_P0_X = 3'd0,
      REG_P0_Y = 3'd1,
      REG_P1_X = 3'd2,
      REG_P1_Y = 3'd3,
      REG_P2_X = 3'd4,
      REG_P2_Y = 3'd5,
      REG_P3_X = 3'd6,
      REG_P3_Y = 3'd7
   } reg_idx_type;

   typedef logic [NUM_PTS-1:0][COORD_W-1:0] ctrl_type;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
   } point_type;

   typedef struct packed {
      logic      valid;
      point_type pt;
   } point_msg_type;

   // One interpolation level: a + floor(t * (b - a) / 2^16).
   function automatic logic [POS_W-1:0] lerp(input logic [POS_W-1:0] a,
                                             input logic [POS_W-1:0] b,
                                             input logic [T_W-1:0] t);
      logic signed [POS_W:0] diff;
      logic signed [POS_W+T_W+1:0] prod;
      diff = signed'({1'b0, b}) - signed'({1'b0, a});
      prod = (POS_W+T_W+2)'(diff) * (POS_W+T_W+2)'(signed'({1'b0, t}));
      prod = prod >>> FRAC_W;
      return a + prod[POS_W-1:0];
   endfunction

endpackage

[src/abp_front.sv]
// Front end: takes curve parameters and evaluates the Bezier point in three pipelined levels.
module abp_front
   import abp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [T_W-1:0]   req_t_frac,
   input  ctrl_type         cp_x,
   input  ctrl_type         cp_y,
   input  logic             q_full,
   output point_msg_type    push
);

   logic                             adv;
   logic                             f0_valid_ff, f1_valid_ff, f2_valid_ff, f3_valid_ff;
   logic [T_W-1:0]                   f0_t_ff, f1_t_ff, f2_t_ff;
   logic [T_W-1:0]                   t_sat_in;
   logic [NUM_PTS-2:0][POS_W-1:0]    ax_ff, ay_ff, ax_in, ay_in;
   logic [NUM_PTS-3:0][POS_W-1:0]    bx_ff, by_ff, bx_in, by_in;
   logic [POS_W-1:0]                 px_ff, py_ff, px_in, py_in;

   // The whole front moves together; it only waits when the finished point cannot enter the queue.
   assign adv = !(f3_valid_ff && q_full);
   assign req_ready = adv;

   assign t_sat_in = (req_t_frac > T_ONE) ? T_ONE : req_t_frac;

   always_comb begin
      for (int i = 0; i < NUM_PTS - 1; i++) begin
         ax_in[i] = lerp({cp_x[i], FRAC_W'(0)}, {cp_x[i+1], FRAC_W'(0)}, f0_t_ff);
         ay_in[i] = lerp({cp_y[i], FRAC_W'(0)}, {cp_y[i+1], FRAC_W'(0)}, f0_t_ff);
      end
      for (int i = 0; i < NUM_PTS - 2; i++) begin
         bx_in[i] = lerp(ax_ff[i], ax_ff[i+1], f1_t_ff);
         by_in[i] = lerp(ay_ff[i], ay_ff[i+1], f1_t_ff);
      end
      px_in = lerp(bx_ff[0], bx_ff[1], f2_t_ff);
      py_in = lerp(by_ff[0], by_ff[1], f2_t_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (adv) begin
         f0_valid_ff <= req_valid;
         f1_valid_ff <= f0_valid_ff;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f0_t_ff <= t_sat_in;
         f1_t_ff <= f0_t_ff;
         f2_t_ff <= f1_t_ff;
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         bx_ff <= bx_in;
         by_ff <= by_in;
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   assign push.valid = f3_valid_ff && !q_full;
   assign push.pt.x = px_ff;
   assign push.pt.y = py_ff;

endmodule

[src/abp_queue.sv]
// Short point queue that decouples the curve evaluator from the pixel writer.
module abp_queue
   import abp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  point_msg_type  push,
   input  logic           pop,
   output logic           full,
   output point_msg_type  head
);

   point_type            mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_W:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full = (count_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.pt;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.pt = mem_ff[rd_ptr_ff];

endmodule

[src/abp_back.sv]
// Back end: walks the nine neighborhood pixels of each point and computes their intensities.
module abp_back
   import abp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  point_msg_type             head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [PIX_W-1:0]   rsp_pixel_x,
   output logic signed [PIX_W-1:0]   rsp_pixel_y,
   output logic [INTEN_W-1:0]        rsp_intensity,
   output logic                      rsp_last_write
);

   logic                      adv, load;

   // Sequencer.
   logic                      busy_ff;
   logic [K_W-1:0]            k_ff;
   point_type                 pt_ff;

   // Offset stage.
   logic                      s1_valid_ff, s1_base_ff, s1_last_ff;
   logic signed [PIX_W-1:0]   s1_cx_ff, s1_cy_ff, s1_cx_in, s1_cy_in;
   logic signed [D_W-1:0]     s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic [FRAC_W-1:0]         frac_x, frac_y;
   logic                      low_x, low_y;
   logic signed [1:0]         off_x, off_y;

   // Square stage.
   logic                      s2_valid_ff, s2_base_ff, s2_last_ff;
   logic signed [PIX_W-1:0]   s2_cx_ff, s2_cy_ff;
   logic signed [2*D_W-1:0]   s2_sqx_in, s2_sqy_in;
   logic [SQ_W-1:0]           s2_sqx_ff, s2_sqy_ff;

   // Weight stage.
   logic                      s3_valid_ff, s3_base_ff, s3_last_ff, s3_far_ff;
   logic signed [PIX_W-1:0]   s3_cx_ff, s3_cy_ff;
   logic [D2_W-1:0]           s3_d2_in, s3_rem_in;
   logic [W_W-1:0]            s3_w_ff;

   // Weight square stage.
   logic                      s4_valid_ff, s4_base_ff, s4_last_ff, s4_far_ff;
   logic signed [PIX_W-1:0]   s4_cx_ff, s4_cy_ff;
   logic [WW_W-1:0]           s4_ww_ff;

   // Output register.
   logic                      rsp_valid_ff, rsp_last_ff;
   logic signed [PIX_W-1:0]   rsp_x_ff, rsp_y_ff;
   logic [INTEN_W-1:0]        rsp_inten_ff, inten_in;
   logic [SCALE_W-1:0]        scaled;

   assign adv = !rsp_valid_ff || rsp_ready;
   assign load = adv && (!busy_ff || (k_ff == LAST_K));
   assign pop = load && head.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff <= FIRST_K;
      end else if (adv) begin
         if (load) begin
            busy_ff <= head.valid;
            k_ff <= FIRST_K;
         end else begin
            k_ff <= k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pt_ff <= head.pt;
      end
   end

   // Base pixel is floor minus one when the fraction is below one half.
   always_comb begin
      frac_x = pt_ff.x[FRAC_W-1:0];
      frac_y = pt_ff.y[FRAC_W-1:0];
      low_x = !frac_x[FRAC_W-1];
      low_y = !frac_y[FRAC_W-1];
      off_x = OFF_X[k_ff];
      off_y = OFF_Y[k_ff];
      s1_cx_in = PIX_W'(pt_ff.x[POS_W-1:FRAC_W]) - PIX_W'(low_x) + PIX_W'(off_x);
      s1_cy_in = PIX_W'(pt_ff.y[POS_W-1:FRAC_W]) - PIX_W'(low_y) + PIX_W'(off_y);
      s1_dx_in = (D_W'(off_x) <<< FRAC_W) + D_W'(32'h8000) - D_W'(frac_x)
                 - (low_x ? D_W'(32'h1_0000) : D_W'(0));
      s1_dy_in = (D_W'(off_y) <<< FRAC_W) + D_W'(32'h8000) - D_W'(frac_y)
                 - (low_y ? D_W'(32'h1_0000) : D_W'(0));
   end

   assign s2_sqx_in = s1_dx_ff * s1_dx_ff;
   assign s2_sqy_in = s1_dy_ff * s1_dy_ff;

   assign s3_d2_in = D2_W'(s2_sqx_ff) + D2_W'(s2_sqy_ff);
   assign s3_rem_in = D2_LIM - s3_d2_in;

   always_comb begin
      scaled = (SCALE_W'(s4_ww_ff) << 8) - SCALE_W'(s4_ww_ff);
      if (s4_base_ff) begin
         inten_in = FULL_INTENSITY;
      end else if (s4_far_ff) begin
         inten_in = ZERO_INTENSITY;
      end else if (scaled[SCALE_W-1:SCALE_W-INT_TOP_W] > INT_TOP_W'(FULL_INTENSITY)) begin
         inten_in = FULL_INTENSITY;
      end else begin
         inten_in = scaled[SCALE_W-INT_TOP_W+INTEN_W-1:SCALE_W-INT_TOP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= busy_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cx_ff <= s1_cx_in;
         s1_cy_ff <= s1_cy_in;
         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
         s1_base_ff <= (k_ff == BASE_K);
         s1_last_ff <= (k_ff == LAST_K);

         s2_cx_ff <= s1_cx_ff;
         s2_cy_ff <= s1_cy_ff;
         s2_base_ff <= s1_base_ff;
         s2_last_ff <= s1_last_ff;
         s2_sqx_ff <= s2_sqx_in[SQ_W-1:0];
         s2_sqy_ff <= s2_sqy_in[SQ_W-1:0];

         s3_cx_ff <= s2_cx_ff;
         s3_cy_ff <= s2_cy_ff;
         s3_base_ff <= s2_base_ff;
         s3_last_ff <= s2_last_ff;
         s3_far_ff <= (s3_d2_in >= D2_LIM);
         s3_w_ff <= s3_rem_in[D2_W-1:D2_W-W_W];

         s4_cx_ff <= s3_cx_ff;
         s4_cy_ff <= s3_cy_ff;
         s4_base_ff <= s3_base_ff;
         s4_last_ff <= s3_last_ff;
         s4_far_ff <= s3_far_ff;
         s4_ww_ff <= WW_W'(s3_w_ff) * WW_W'(s3_w_ff);

         rsp_x_ff <= s4_cx_ff;
         rsp_y_ff <= s4_cy_ff;
         rsp_inten_ff <= inten_in;
         rsp_last_ff <= s4_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_x = rsp_x_ff;
   assign rsp_pixel_y = rsp_y_ff;
   assign rsp_intensity = rsp_inten_ff;
   assign rsp_last_write = rsp_last_ff;

endmodule

[src/antialiased_bezier_plotter_top.sv]
// Top level of the antialiased cubic Bezier point plotter with its control point registers.
//
// Each request carries a curve parameter t in Q1.16 (values above one are treated as one) and
// produces nine pixel writes on the response channel: the 3x3 neighborhood around the
// base pixel of the curve point, the base pixel at full intensity and the others weighted by
// their squared distance to the point, last_write marking the ninth. The response side issues
// one write per cycle while rsp_ready is held high; the throughput for a steady stream of
// requests is set by the single pixel-writer pipeline in the back end. The front end evaluates
// the point by de Casteljau in three multiplier stages plus an input register, and a four-entry
// point queue lets it keep taking requests while the back end is still writing earlier points.
// Control points are written through the csr port, one coordinate per register, and are
// clamped to the canvas; they must only be changed while no request is in flight.
module antialiased_bezier_plotter_top
   import abp_pkg::*;
#(
   parameter int CANVAS_SIZE = DEFAULT_CANVAS_SIZE
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [T_W-1:0]            req_t_frac,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [PIX_W-1:0]   rsp_pixel_x,
   output logic signed [PIX_W-1:0]   rsp_pixel_y,
   output logic [INTEN_W-1:0]        rsp_intensity,
   output logic                      rsp_last_write,
   input  logic                      csr_we,
   input  logic [REG_IDX_W-1:0]      csr_index,
   input  logic [COORD_W-1:0]        csr_wdata
);

   localparam logic [CANVAS_CMP_W-1:0] CANVAS_MAX = CANVAS_CMP_W'(CANVAS_SIZE - 1);

   ctrl_type            cp_x_ff, cp_y_ff;
   logic [COORD_W-1:0]  wval_in;
   logic                q_full, q_pop;
   point_msg_type       q_push, q_head;

   // Coordinates beyond the canvas are clamped to its last column or row.
   assign wval_in = (CANVAS_CMP_W'(csr_wdata) > CANVAS_MAX) ? CANVAS_MAX[COORD_W-1:0]
                                                            : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_x_ff <= '0;
         cp_y_ff <= '0;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_index))
            REG_P0_X: cp_x_ff[0] <= wval_in;
            REG_P0_Y: cp_y_ff[0] <= wval_in;
            REG_P1_X: cp_x_ff[1] <= wval_in;
            REG_P1_Y: cp_y_ff[1] <= wval_in;
            REG_P2_X: cp_x_ff[2] <= wval_in;
            REG_P2_Y: cp_y_ff[2] <= wval_in;
            REG_P3_X: cp_x_ff[3] <= wval_in;
            REG_P3_Y: cp_y_ff[3] <= wval_in;
            default: ;
         endcase
      end
   end

   // Curve evaluation.
   abp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_t_frac (req_t_frac),
      .cp_x       (cp_x_ff),
      .cp_y       (cp_y_ff),
      .q_full     (q_full),
      .push       (q_push)
   );

   // Points waiting for the pixel writer.
   abp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (q_pop),
      .full  (q_full),
      .head  (q_head)
   );

   // Neighborhood walk and intensity pipeline, ending in the response register.
   abp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_intensity  (rsp_intensity),
      .rsp_last_write (rsp_last_write)
   );

endmodule

[src/abp_checker.sv]
// Port-level checks of the plotter's response stream, bound to the top level.
module abp_checker
   import abp_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [PIX_W-1:0]   rsp_pixel_x,
   input logic signed [PIX_W-1:0]   rsp_pixel_y,
   input logic [INTEN_W-1:0]        rsp_intensity,
   input logic                      rsp_last_write
);

   logic [K_W-1:0] wr_cnt_ff;
   logic           req_seen;

   assign req_seen = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_cnt_ff <= FIRST_K;
      end else if (rsp_valid && rsp_ready) begin
         wr_cnt_ff <= (wr_cnt_ff == LAST_K) ? FIRST_K : wr_cnt_ff + 1'b1;
      end
   end

   // Every ninth write, and only that one, closes a request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_write == (wr_cnt_ff == LAST_K)))
      else $error("last_write out of step with the nine-write groups");

   // The second write of each group is the base pixel.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && wr_cnt_ff == BASE_K) |-> (rsp_intensity == FULL_INTENSITY))
      else $error("base pixel written below full intensity");

   // Written pixels stay within two pixels below the canvas and one pixel above it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixel_x >= -12'sd2 && rsp_pixel_x <= 12'sd1024 &&
                     rsp_pixel_y >= -12'sd2 && rsp_pixel_y <= 12'sd1024))
      else $error("pixel coordinate outside the canvas margin");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel_x) &&
                                     $stable(rsp_pixel_y) && $stable(rsp_intensity) &&
                                     $stable(rsp_last_write)))
      else $error("stalled response changed");

   // No response appears before any request has been taken since reset.
   logic any_req_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         any_req_ff <= 1'b0;
      end else if (req_seen) begin
         any_req_ff <= 1'b1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> any_req_ff)
      else $error("response without a request");

endmodule

bind antialiased_bezier_plotter_top abp_checker u_abp_checker (.*);
